@@ hdl/rotation_synced_pixel_scheduler_macros.svh @@
`ifndef ROTATION_SYNCED_PIXEL_SCHEDULER_MACROS_SVH
`define ROTATION_SYNCED_PIXEL_SCHEDULER_MACROS_SVH

// same-cycle implication, held off in reset
`define RSPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsps: same-cycle check failed");

// next-cycle implication, held off in reset
`define RSPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsps: next-cycle check failed");

`endif

@@ hdl/rsps_pkg.sv @@
package rsps_pkg;

  localparam int NUM_COLUMNS      = 256;
  localparam int BYTES_PER_COLUMN = 4;
  localparam int FRAME_SPAN       = NUM_COLUMNS * BYTES_PER_COLUMN;
  localparam int COL_W            = $clog2(FRAME_SPAN);

  localparam logic [15:0] LAP_SAT   = 16'hffff;
  localparam logic [7:0]  HALL_SAT  = 8'hff;
  localparam logic [15:0] LAP_MIN   = 16'h0003;
  localparam logic [15:0] LAP_MAX   = 16'h00ff;
  localparam logic [15:0] FRAME_STEP = 16'(FRAME_SPAN);

  localparam logic [2:0] CFG_ROTATION_OFFSET = 3'd0;
  localparam logic [2:0] CFG_MIRROR_ENABLE   = 3'd1;
  localparam logic [2:0] CFG_ANIM_HOLD       = 3'd2;
  localparam logic [2:0] CFG_HALL_GUARD      = 3'd3;
  localparam logic [2:0] CFG_STANDBY_LIMIT   = 3'd4;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_HALL  = 2'd1,
    OP_MATCH = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_NONE       = 3'd0,
    KIND_PERIOD     = 3'd1,
    KIND_HALL_BLANK = 3'd2,
    KIND_PIXEL      = 3'd3,
    KIND_TIMEOUT    = 3'd4
  } kind_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] fine_count;
  } in_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] pixel_period;
    logic        pixel_timer_on;
    logic [15:0] front_addr;
    logic [15:0] back_addr;
    logic        back_valid;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  rotation_offset;
    logic        mirror_enable;
    logic [7:0]  anim_hold;
    logic [7:0]  hall_guard;
    logic [15:0] standby_limit;
  } cfg_t;

  typedef logic [COL_W-1:0] start_col_tab_t [256];

  function automatic start_col_tab_t build_start_col();
    start_col_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = COL_W'((i % NUM_COLUMNS) * BYTES_PER_COLUMN);
    end
    return tab;
  endfunction

  localparam start_col_tab_t START_COL = build_start_col();

endpackage

@@ hdl/rsps_core.sv @@
module rsps_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  rsps_pkg::in_word_t   word,
  input  rsps_pkg::cfg_t       cfg,
  output rsps_pkg::out_word_t  res
);

  logic [15:0]                lap_ticks_r, lap_ticks_nxt;
  logic [7:0]                 hall_ticks_r, hall_ticks_nxt;
  logic [7:0]                 anim_laps_r, anim_laps_nxt;
  logic [15:0]                frame_offset_r, frame_offset_nxt;
  logic [rsps_pkg::COL_W-1:0] column_addr_r, column_addr_nxt;
  logic                       mirror_latched_r, mirror_latched_nxt;
  logic                       running_r, running_nxt;
  logic [rsps_pkg::COL_W:0]   col_sum;

  assign col_sum = {1'b0, column_addr_r} + (rsps_pkg::COL_W + 1)'(rsps_pkg::BYTES_PER_COLUMN);

  always_comb begin
    lap_ticks_nxt      = lap_ticks_r;
    hall_ticks_nxt     = hall_ticks_r;
    anim_laps_nxt      = anim_laps_r;
    frame_offset_nxt   = frame_offset_r;
    column_addr_nxt    = column_addr_r;
    mirror_latched_nxt = mirror_latched_r;
    running_nxt        = running_r;
    res                = '0;
    res.kind           = rsps_pkg::KIND_NONE;
    unique case (word.op)
      rsps_pkg::OP_TICK: begin
        if (hall_ticks_r != rsps_pkg::HALL_SAT) hall_ticks_nxt = hall_ticks_r + 8'd1;
        if (lap_ticks_r != rsps_pkg::LAP_SAT) lap_ticks_nxt = lap_ticks_r + 16'd1;
      end
      rsps_pkg::OP_HALL: begin
        if (hall_ticks_r > cfg.hall_guard) begin
          if (anim_laps_r != cfg.anim_hold) begin
            anim_laps_nxt = anim_laps_r + 8'd1;
          end else begin
            anim_laps_nxt    = '0;
            frame_offset_nxt = frame_offset_r + rsps_pkg::FRAME_STEP;
          end
          if (lap_ticks_r < rsps_pkg::LAP_MAX && lap_ticks_r > rsps_pkg::LAP_MIN) begin
            res.pixel_period   = {lap_ticks_r[7:0], word.fine_count};
            column_addr_nxt    = rsps_pkg::START_COL[cfg.rotation_offset];
            mirror_latched_nxt = cfg.mirror_enable;
            running_nxt        = 1'b1;
            res.kind           = rsps_pkg::KIND_PERIOD;
          end else begin
            running_nxt = 1'b0;
            res.kind    = rsps_pkg::KIND_HALL_BLANK;
          end
          lap_ticks_nxt = '0;
        end
        hall_ticks_nxt = '0;
      end
      rsps_pkg::OP_MATCH: begin
        if (running_r) begin
          if (lap_ticks_r < cfg.standby_limit) begin
            res.front_addr = frame_offset_r + 16'(column_addr_r);
            if (mirror_latched_r) begin
              res.back_addr  = frame_offset_r + rsps_pkg::FRAME_STEP - 16'(column_addr_r);
              res.back_valid = 1'b1;
            end
            if (col_sum >= (rsps_pkg::COL_W + 1)'(rsps_pkg::FRAME_SPAN)) begin
              column_addr_nxt = rsps_pkg::COL_W'(col_sum
                                - (rsps_pkg::COL_W + 1)'(rsps_pkg::FRAME_SPAN));
            end else begin
              column_addr_nxt = col_sum[rsps_pkg::COL_W-1:0];
            end
            res.kind = rsps_pkg::KIND_PIXEL;
          end else begin
            running_nxt = 1'b0;
            res.kind    = rsps_pkg::KIND_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
    res.pixel_timer_on = running_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lap_ticks_r      <= '0;
      hall_ticks_r     <= '0;
      anim_laps_r      <= '0;
      frame_offset_r   <= '0;
      column_addr_r    <= '0;
      mirror_latched_r <= 1'b0;
      running_r        <= 1'b0;
    end else if (step) begin
      lap_ticks_r      <= lap_ticks_nxt;
      hall_ticks_r     <= hall_ticks_nxt;
      anim_laps_r      <= anim_laps_nxt;
      frame_offset_r   <= frame_offset_nxt;
      column_addr_r    <= column_addr_nxt;
      mirror_latched_r <= mirror_latched_nxt;
      running_r        <= running_nxt;
    end
  end

endmodule

@@ hdl/rotation_synced_pixel_scheduler.sv @@
// channel   dir  handshake            payload
// in_       in   in_valid/in_ready    in_data   (op, fine_count)
// out_      out  out_valid/out_ready  out_data  (kind .. back_valid)
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word per cycle unless a result waits on out_ready. The result is
// registered on the state update after acceptance (input register, then
// result register); the core makes a single state update per word.
// While a result waits on out_ready, an empty input register still takes one
// word; in_ready then drops. cfg_ready is always high.
// Synchronous active-low reset, no clearing pass.
module rotation_synced_pixel_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsps_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rsps_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  logic                in_valid_r;
  rsps_pkg::in_word_t  in_word_r;
  logic                out_valid_r;
  rsps_pkg::out_word_t out_word_r;
  rsps_pkg::cfg_t      cfg_r;
  rsps_pkg::out_word_t res;
  logic                advance;
  logic                step;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !in_valid_r || advance;
  assign step      = in_valid_r && advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  rsps_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .word  (in_word_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance) out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_word_r <= in_data;
    if (step) out_word_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotation_offset <= 8'd0;
      cfg_r.mirror_enable   <= 1'b0;
      cfg_r.anim_hold       <= 8'd6;
      cfg_r.hall_guard      <= 8'd4;
      cfg_r.standby_limit   <= 16'd610;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rsps_pkg::CFG_ROTATION_OFFSET: cfg_r.rotation_offset <= cfg_data[7:0];
        rsps_pkg::CFG_MIRROR_ENABLE:   cfg_r.mirror_enable   <= cfg_data[0];
        rsps_pkg::CFG_ANIM_HOLD:       cfg_r.anim_hold       <= cfg_data[7:0];
        rsps_pkg::CFG_HALL_GUARD:      cfg_r.hall_guard      <= cfg_data[7:0];
        rsps_pkg::CFG_STANDBY_LIMIT:   cfg_r.standby_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/rsps_checker.sv @@
`include "rotation_synced_pixel_scheduler_macros.svh"

module rsps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input rsps_pkg::out_word_t out_data
);

  // stalled result word holds
  `RSPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // addresses only on a pixel word
  `RSPS_ASSERT_NOW(a_addr_pixel_only, out_valid && out_data.kind != rsps_pkg::KIND_PIXEL,
    out_data.front_addr == 16'd0 && out_data.back_addr == 16'd0 && !out_data.back_valid)

  // period set starts the timer, blanks stop it
  `RSPS_ASSERT_NOW(a_timer_start, out_valid && out_data.kind == rsps_pkg::KIND_PERIOD, out_data.pixel_timer_on)
  `RSPS_ASSERT_NOW(a_timer_stop, out_valid && (out_data.kind == rsps_pkg::KIND_HALL_BLANK || out_data.kind == rsps_pkg::KIND_TIMEOUT), !out_data.pixel_timer_on)

endmodule

bind rotation_synced_pixel_scheduler rsps_checker u_rsps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
